// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- src/gmf_pkg.sv -----
`timescale 1ns / 1ps

package gmf_pkg;

    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SATW   = PROD_W + 1;

    localparam int IN_TDATA_W  = 264;
    localparam int OUT_TDATA_W = 168;
    localparam int APB_AW      = 3;

    localparam logic [0:0] REG_ENTRIES = 1'b0;
    localparam logic       FUNC_LOAD   = 1'b0;
    localparam logic       FUNC_EVAL   = 1'b1;

    localparam logic [30:0] T_ONE     = 31'h4000_0000;
    localparam logic [61:0] EXP_LIMIT = 62'd786432;
    localparam logic [16:0] Q_LOG2E   = 17'd94548;
    localparam logic [15:0] Q_LN2     = 16'd45426;
    localparam logic [2:0]  EXP_TERMS = 3'd6;

    localparam logic signed [SATW-1:0] S32_MAX = 67'sd2147483647;
    localparam logic signed [SATW-1:0] S32_MIN = -67'sd2147483648;

    typedef struct packed {
        logic signed [31:0] h;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [17:0] c;
        logic signed [17:0] s;
        logic [30:0]        ivx;
        logic [30:0]        ivy;
    } t_entry;

    typedef struct packed {
        logic start;
        logic we;
        logic take;
    } t_core_ctl;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_core_sts;

    typedef struct packed {
        logic        sat;
        logic [31:0] py;
        logic [31:0] px;
        logic [31:0] gy;
        logic [31:0] gx;
        logic [31:0] fv;
    } t_result;

    typedef enum logic [5:0] {
        S_IDLE, S_READ,
        S_ROT0, S_ROT1, S_ROT2, S_ROT3,
        S_SQU, S_PU, S_SQV, S_AHI, S_ALO, S_PV, S_BHI, S_BLO,
        S_WX0, S_WX1, S_WY0, S_WY1,
        S_LOG, S_FRAC, S_GLN,
        S_EXPA, S_EXPB, S_EXPC, S_EXPD,
        S_HEX, S_GV, S_TX, S_TY, S_ACC,
        S_FIN
    } t_state;

    // Returns {clipped, value} for a clip to signed 32 bits.
    function automatic logic [32:0] sat32(input logic signed [SATW-1:0] x);
        logic [32:0] res;
        if (x > S32_MAX) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (x < S32_MIN) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, x[31:0]};
        end
        return res;
    endfunction

    // Reciprocals round up, exact for dividends below 2^30.
    function automatic logic [30:0] exp_recip(input logic [2:0] k);
        logic [30:0] m;
        case (k)
            3'd3:    m = 31'd1431655766;
            3'd5:    m = 31'd858993460;
            3'd6:    m = 31'd715827883;
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic exp_needs_recip(input logic [2:0] k);
        logic r;
        case (k) inside
            3'd3, 3'd5, 3'd6: r = 1'b1;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] exp_shift(input logic [2:0] k);
        logic [1:0] sh;
        case (k)
            3'd2:    sh = 2'd1;
            3'd4:    sh = 2'd2;
            default: sh = 2'd0;
        endcase
        return sh;
    endfunction

endpackage

// ----- src/gmf_ram.sv -----
`timescale 1ns / 1ps

module gmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/gmf_mul.sv -----
`timescale 1ns / 1ps

module gmf_mul import gmf_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ----- src/gmf_core.sv -----
`timescale 1ns / 1ps

module gmf_core import gmf_pkg::*; #(
    parameter int MAX_ENTRIES = 32,
    localparam int IW = $clog2(MAX_ENTRIES + 1),
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int SW = 32 + IW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_core_ctl          i_ctl,
    input  logic [IW-1:0]      i_count,
    input  logic [AW-1:0]      i_waddr,
    input  t_entry             i_wdata,
    input  logic signed [31:0] i_query_x,
    input  logic signed [31:0] i_query_y,
    output t_core_sts          o_sts,
    output t_result            o_res
);

    t_state r_state, n_state;

    logic [IW-1:0]        r_idx, r_cnt;
    logic signed [31:0]   r_qx, r_qy;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [31:0]   r_u, r_v, r_pu, r_pv, r_wx, r_wy, r_gv;
    logic [46:0]          r_qu, r_qv;
    logic [62:0]          r_ab;
    logic [19:0]          r_e;
    logic                 r_ez;
    logic [4:0]           r_n;
    logic [15:0]          r_g;
    logic [30:0]          r_t;
    logic [2:0]           r_k;
    logic [16:0]          r_ex;
    logic signed [SW-1:0] r_sv, r_sx, r_sy;
    logic                 r_sat;

    logic [$bits(t_entry)-1:0] w_rdata;
    t_entry                    w_ent;
    logic                      w_re;
    logic signed [MUL_W-1:0]   w_a, w_b;
    logic signed [PROD_W-1:0]  w_p;

    logic [32:0] w_rot_u, w_rot_v, w_ps, w_wx, w_wy, w_term;
    logic [32:0] w_fv, w_gx, w_gy, w_px;
    logic [29:0] w_x;
    logic [5:0]  w_shamt;

    gmf_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(MAX_ENTRIES)
    ) u_gmf_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctl.we),
        .i_waddr(i_waddr),
        .i_wdata(i_wdata),
        .i_re   (w_re),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(w_rdata)
    );

    gmf_mul u_gmf_mul (
        .i_clk(i_clk),
        .i_a  (w_a),
        .i_b  (w_b),
        .o_p  (w_p)
    );

    assign w_ent   = t_entry'(w_rdata);
    assign w_x     = w_p[45:16];
    assign w_shamt = 6'd14 + 6'(r_n);

    always_comb begin
        w_rot_u = sat32(SATW'(r_acc >>> 16) - SATW'(w_ent.cx));
        w_rot_v = sat32(SATW'(r_acc >>> 16) - SATW'(w_ent.cy));
        w_ps    = sat32(SATW'(w_p) >>> 16);
        w_wx    = sat32((SATW'(r_acc) + SATW'(w_p)) >>> 16);
        w_wy    = sat32((SATW'(r_acc) - SATW'(w_p)) >>> 16);
        w_term  = sat32((-SATW'(w_p)) >>> 16);
        w_fv    = sat32(SATW'(r_sv));
        w_gx    = sat32(SATW'(r_sx));
        w_gy    = sat32(SATW'(r_sy));
        w_px    = sat32(-SATW'($signed(w_gy[31:0])));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_ctl.start) n_state = (i_count == '0) ? S_FIN : S_READ;
            S_READ:  n_state = S_ROT0;
            S_ROT0:  n_state = S_ROT1;
            S_ROT1:  n_state = S_ROT2;
            S_ROT2:  n_state = S_ROT3;
            S_ROT3:  n_state = S_SQU;
            S_SQU:   n_state = S_PU;
            S_PU:    n_state = S_SQV;
            S_SQV:   n_state = S_AHI;
            S_AHI:   n_state = S_ALO;
            S_ALO:   n_state = S_PV;
            S_PV:    n_state = S_BHI;
            S_BHI:   n_state = S_BLO;
            S_BLO:   n_state = S_WX0;
            S_WX0:   n_state = S_WX1;
            S_WX1:   n_state = S_WY0;
            S_WY0:   n_state = S_WY1;
            S_WY1:   n_state = S_LOG;
            S_LOG:   n_state = S_FRAC;
            S_FRAC:  n_state = S_GLN;
            S_GLN:   n_state = S_EXPA;
            S_EXPA:  n_state = S_EXPB;
            S_EXPB: begin
                if (exp_needs_recip(r_k)) begin
                    n_state = S_EXPC;
                end else begin
                    n_state = (r_k == 3'd1) ? S_EXPD : S_EXPA;
                end
            end
            S_EXPC:  n_state = S_EXPA;
            S_EXPD:  n_state = S_HEX;
            S_HEX:   n_state = S_GV;
            S_GV:    n_state = S_TX;
            S_TX:    n_state = S_TY;
            S_TY:    n_state = S_ACC;
            S_ACC:   n_state = (IW'(r_idx + 1'b1) < r_cnt) ? S_READ : S_FIN;
            S_FIN:   if (i_ctl.take) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_re = 1'b0;
        w_a  = '0;
        w_b  = '0;
        unique case (r_state)
            S_READ: w_re = 1'b1;
            S_ROT0: begin w_a = MUL_W'(r_qx);  w_b = MUL_W'(w_ent.c); end
            S_ROT1: begin w_a = MUL_W'(r_qy);  w_b = MUL_W'(w_ent.s); end
            S_ROT2: begin w_a = MUL_W'(r_qx);  w_b = MUL_W'(w_ent.s); end
            S_ROT3: begin w_a = MUL_W'(r_qy);  w_b = MUL_W'(w_ent.c); end
            S_SQU:  begin w_a = MUL_W'(r_u);   w_b = MUL_W'(r_u); end
            S_PU:   begin w_a = MUL_W'(r_u);   w_b = MUL_W'(w_ent.ivx); end
            S_SQV:  begin w_a = MUL_W'(r_v);   w_b = MUL_W'(r_v); end
            S_AHI:  begin w_a = MUL_W'(r_qu[46:16]); w_b = MUL_W'(w_ent.ivx); end
            S_ALO:  begin w_a = MUL_W'(r_qu[15:0]);  w_b = MUL_W'(w_ent.ivx); end
            S_PV:   begin w_a = MUL_W'(r_v);   w_b = MUL_W'(w_ent.ivy); end
            S_BHI:  begin w_a = MUL_W'(r_qv[46:16]); w_b = MUL_W'(w_ent.ivy); end
            S_BLO:  begin w_a = MUL_W'(r_qv[15:0]);  w_b = MUL_W'(w_ent.ivy); end
            S_WX0:  begin w_a = MUL_W'(w_ent.c); w_b = MUL_W'(r_pu); end
            S_WX1:  begin w_a = MUL_W'(w_ent.s); w_b = MUL_W'(r_pv); end
            S_WY0:  begin w_a = MUL_W'(w_ent.c); w_b = MUL_W'(r_pv); end
            S_WY1:  begin w_a = MUL_W'(w_ent.s); w_b = MUL_W'(r_pu); end
            S_LOG:  begin w_a = MUL_W'(r_e);   w_b = MUL_W'(Q_LOG2E); end
            S_FRAC: begin w_a = MUL_W'(w_p[31:16]); w_b = MUL_W'(Q_LN2); end
            S_EXPA: begin w_a = MUL_W'(r_g);   w_b = MUL_W'(r_t); end
            S_EXPB: begin w_a = MUL_W'(w_x);   w_b = MUL_W'(exp_recip(r_k)); end
            S_HEX:  begin w_a = MUL_W'(w_ent.h); w_b = MUL_W'(r_ex); end
            S_TX:   begin w_a = MUL_W'(r_gv);  w_b = MUL_W'(r_wx); end
            S_TY:   begin w_a = MUL_W'(r_gv);  w_b = MUL_W'(r_wy); end
            default: begin w_a = '0; w_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    r_cnt <= i_count;
                    r_idx <= '0;
                    r_qx  <= i_query_x;
                    r_qy  <= i_query_y;
                    r_sv  <= '0;
                    r_sx  <= '0;
                    r_sy  <= '0;
                    r_sat <= 1'b0;
                end
            end
            S_ROT1: r_acc <= w_p;
            S_ROT2: r_acc <= r_acc - w_p;
            S_ROT3: begin
                r_u   <= $signed(w_rot_u[31:0]);
                r_sat <= r_sat | w_rot_u[32];
                r_acc <= w_p;
            end
            S_SQU: r_acc <= r_acc + w_p;
            S_PU: begin
                r_v   <= $signed(w_rot_v[31:0]);
                r_sat <= r_sat | w_rot_v[32];
                r_qu  <= w_p[62:16];
            end
            S_SQV: begin
                r_pu  <= $signed(w_ps[31:0]);
                r_sat <= r_sat | w_ps[32];
            end
            S_AHI: r_qv <= w_p[62:16];
            S_ALO: r_ab <= w_p[62:0];
            S_PV:  r_ab <= r_ab + 63'(w_p[PROD_W-1:16]);
            S_BHI: begin
                r_pv  <= $signed(w_ps[31:0]);
                r_sat <= r_sat | w_ps[32];
            end
            S_BLO: r_ab <= r_ab + w_p[62:0];
            S_WX0: r_ab <= r_ab + 63'(w_p[PROD_W-1:16]);
            S_WX1: begin
                r_acc <= w_p;
                r_e   <= r_ab[20:1];
                r_ez  <= (r_ab[62:1] >= EXP_LIMIT);
            end
            S_WY0: begin
                r_wx  <= $signed(w_wx[31:0]);
                r_sat <= r_sat | w_wx[32];
            end
            S_WY1: r_acc <= w_p;
            S_LOG: begin
                r_wy  <= $signed(w_wy[31:0]);
                r_sat <= r_sat | w_wy[32];
            end
            S_FRAC: begin
                r_n <= w_p[36:32];
                r_t <= T_ONE;
                r_k <= EXP_TERMS;
            end
            S_GLN: r_g <= w_p[31:16];
            S_EXPB: begin
                if (!exp_needs_recip(r_k)) begin
                    r_t <= T_ONE - 31'(w_x >> exp_shift(r_k));
                    r_k <= r_k - 3'd1;
                end
            end
            S_EXPC: begin
                r_t <= T_ONE - 31'(w_p[61:32]);
                r_k <= r_k - 3'd1;
            end
            S_EXPD: r_ex <= r_ez ? '0 : 17'(r_t >> w_shamt);
            S_GV: begin
                r_gv <= $signed(w_p[47:16]);
                r_sv <= r_sv + SW'($signed(w_p[47:16]));
            end
            S_TY: begin
                r_sx  <= r_sx + SW'($signed(w_term[31:0]));
                r_sat <= r_sat | w_term[32];
            end
            S_ACC: begin
                r_sy  <= r_sy + SW'($signed(w_term[31:0]));
                r_sat <= r_sat | w_term[32];
                r_idx <= IW'(r_idx + 1'b1);
            end
            default: begin
            end
        endcase
    end

    assign o_sts.idle      = (r_state == S_IDLE);
    assign o_sts.res_valid = (r_state == S_FIN);

    assign o_res.fv  = w_fv[31:0];
    assign o_res.gx  = w_gx[31:0];
    assign o_res.gy  = w_gy[31:0];
    assign o_res.px  = w_px[31:0];
    assign o_res.py  = w_gx[31:0];
    assign o_res.sat = r_sat | w_fv[32] | w_gx[32] | w_gy[32] | w_px[32];

endmodule

// ----- src/gaussian_mixture_field_eval_unit.sv -----
`timescale 1ns / 1ps

// Sums rotated 2D Gaussians and their gradients at a query point, in Q16.16.
// A load word (tuser low) writes one table entry. An evaluate word (tuser
// high) works through the entries in use one after another, since every
// product of an entry, exponential included, goes in turn through the single
// registered 33x33 multiplier. The next word is accepted as soon as the
// result is in the output register. Table entries read before they are loaded
// hold no defined value.
module gaussian_mixture_field_eval_unit import gmf_pkg::*; #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // entry_index, height_in, centre_x, centre_y, cos_angle, sin_angle,
    // inv_var_x, inv_var_y, query_x, query_y, zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // func
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // field_value, grad_x, grad_y, perp_x, perp_y, saturated, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int IW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [5:0]             r_entries;
    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;

    t_core_ctl w_ctl;
    t_core_sts w_sts;
    t_result   w_res;
    t_entry    w_ent;
    logic      w_acc;
    logic [8:0] w_slot;
    logic [8:0] w_lim;
    logic [IW-1:0] w_count;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ENTRIES) ? 32'(r_entries) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_ENTRIES) begin
            r_entries <= pwdata[5:0];
        end
    end

    assign w_lim   = (9'(r_entries) > 9'(MAX_ENTRIES)) ? 9'(MAX_ENTRIES) : 9'(r_entries);
    assign w_count = IW'(w_lim);
    assign w_slot  = 9'(s_tdata[4:0]);

    assign w_ent.h   = $signed(s_tdata[36:5]);
    assign w_ent.cx  = $signed(s_tdata[68:37]);
    assign w_ent.cy  = $signed(s_tdata[100:69]);
    assign w_ent.c   = $signed(s_tdata[118:101]);
    assign w_ent.s   = $signed(s_tdata[136:119]);
    assign w_ent.ivx = s_tdata[167:137];
    assign w_ent.ivy = s_tdata[198:168];

    assign s_tready   = w_sts.idle;
    assign w_acc      = s_tvalid && s_tready;
    assign w_ctl.start = w_acc && (s_tuser == FUNC_EVAL);
    assign w_ctl.we    = w_acc && (s_tuser == FUNC_LOAD) && (w_slot < 9'(MAX_ENTRIES));
    assign w_ctl.take  = w_sts.res_valid && (!r_m_valid || m_tready);

    gmf_core #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_gmf_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_count  (w_count),
        .i_waddr  (w_slot[AW-1:0]),
        .i_wdata  (w_ent),
        .i_query_x($signed(s_tdata[230:199])),
        .i_query_y($signed(s_tdata[262:231])),
        .o_sts    (w_sts),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_ctl.take) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.take) begin
            r_m_data <= {7'd0, w_res.sat, w_res.py, w_res.px, w_res.gy, w_res.gx, w_res.fv};
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

endmodule

// ----- src/gmf_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gmf_checker import gmf_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [31:0] w_gy;
    logic [31:0] w_px;

    assign w_gy = m_tdata[95:64];
    assign w_px = m_tdata[127:96];

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    `ASSERT_IMPLY(a_perp_y, i_clk, i_rst_n, m_tvalid, m_tdata[159:128] == m_tdata[63:32])
    `ASSERT_IMPLY(a_perp_x, i_clk, i_rst_n, m_tvalid && (w_gy != 32'h8000_0000), (w_px + w_gy) == 32'd0)
    `ASSERT_NEXT(a_eval_busy, i_clk, i_rst_n, s_tvalid && s_tready && (s_tuser == FUNC_EVAL), !s_tready)

endmodule

bind gaussian_mixture_field_eval_unit gmf_checker u_gmf_checker (.*);
